// ===== rtl/agsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agsd_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package agsd_pkg;
    localparam int WindowDepth = 20;
    localparam int MinSamples  = 5;
    localparam int WinAw       = $clog2(WindowDepth);
    localparam int FillW       = $clog2(WindowDepth + 1);

    localparam logic [1:0] REG_SEED      = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_LOSS      = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic capture;     // latch input item, compute gap
        logic scan_start;  // reset rank scan
        logic scan_outer;  // advance candidate
        logic scan_inner;  // accumulate compare
        logic decide;      // baseline known: limit multiply
        logic commit;      // update state, load output register
    } agsd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic item_ok;
        logic need_scan;
        logic inner_last;
        logic outer_last;
        logic found;
    } agsd_sts_t;
endpackage

// ===== rtl/agsd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agsd_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module agsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 20
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/agsd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agsd_ctrl
// Sequencer: capture, median rank scan, decision, commit, output hold.
// ----------------------------------------------------------------------------
module agsd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               out_valid,
    input  logic               out_stall,
    input  agsd_pkg::agsd_sts_t sts,
    output agsd_pkg::agsd_cmd_t cmd
);
    import agsd_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CHECK  = 7'b0000010,
        S_OUTER  = 7'b0000100,
        S_INNER  = 7'b0001000,
        S_EVAL   = 7'b0010000,
        S_DECIDE = 7'b0100000,
        S_COMMIT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // output register may be full; commit waits for it to drain or be taken
    logic out_free;
    assign out_free = !out_valid || !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.item_ok && sts.need_scan)
                begin
                    cmd.scan_start = 1'b1;
                    state_next = S_OUTER;
                end
                else if (sts.item_ok)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_OUTER:
            begin
                cmd.scan_outer = 1'b1;
                state_next = S_INNER;
            end
            S_INNER:
            begin
                cmd.scan_inner = 1'b1;
                if (sts.inner_last)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (sts.found || sts.outer_last)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    state_next = S_OUTER;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

// ===== rtl/agsd_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agsd_dp
// Datapath: gap, window RAM, rank-count median, limit, totals, result reg.
// ----------------------------------------------------------------------------
module agsd_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  agsd_pkg::agsd_cmd_t cmd,
    output agsd_pkg::agsd_sts_t sts,
    input  logic [15:0]         seed_cycle_ms,
    input  logic [15:0]         threshold_q8,
    input  logic [15:0]         loss_target,
    input  logic [47:0]         in_arrival,
    input  logic [63:0]         in_sequence,
    input  logic                in_ok,
    input  logic                out_stall,
    output logic                out_valid,
    output logic                o_accepted,
    output logic                o_first,
    output logic                o_stall_flag,
    output logic [31:0]         o_recovery,
    output logic [31:0]         o_gap,
    output logic [31:0]         o_baseline,
    output logic                o_seq_break,
    output logic [31:0]         o_flagged,
    output logic [31:0]         o_received,
    output logic [47:0]         o_rec_total,
    output logic                o_stop
);
    import agsd_pkg::*;

    localparam logic [FillW-1:0] FILL_MAX = FillW'(WindowDepth);
    localparam logic [FillW-1:0] FILL_MIN = FillW'(MinSamples);
    localparam logic [WinAw-1:0] IDX_LAST = WinAw'(WindowDepth - 1);

    logic              have_prior_reg;
    logic [63:0]       prior_seq_reg;
    logic [47:0]       prior_arr_reg;
    logic [FillW-1:0]  fill_reg;
    logic [WinAw-1:0]  oldest_reg;
    logic [31:0]       acc_total_reg;
    logic [31:0]       stall_total_reg;
    logic [47:0]       rec_sum_reg;

    // item registers
    logic              ok_reg;
    logic              first_reg;
    logic [47:0]       arr_reg;
    logic [63:0]       seq_reg;
    logic [31:0]       gap_reg;
    logic [31:0]       base_reg;
    logic [47:0]       limit_reg;

    // scan registers
    logic [FillW-1:0]  oi_reg;
    logic [FillW-1:0]  ii_reg;
    logic [31:0]       cand_reg;
    logic [FillW-1:0]  less_reg;
    logic [FillW-1:0]  same_reg;
    logic              rd_phase_reg;
    logic              found_reg;

    // ring-address helper: (oldest + i) mod depth, i < depth
    function automatic logic [WinAw-1:0] ring(input logic [WinAw-1:0] base,
                                              input logic [FillW-1:0] off);
        logic [FillW:0] s;
        begin
            s = {1'b0, FillW'(base)} + {1'b0, off};
            if (s >= (FillW + 1)'(WindowDepth))
            begin
                s = s - (FillW + 1)'(WindowDepth);
            end
            ring = s[WinAw-1:0];
        end
    endfunction

    // RAM
    logic             ram_we;
    logic [WinAw-1:0] ram_waddr;
    logic [WinAw-1:0] ram_raddr;
    logic [31:0]      ram_rdata;

    agsd_ram #(.WIDTH(32), .DEPTH(WindowDepth)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (gap_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Scan: S_OUTER issues read of candidate; S_INNER reads each entry.
    // rd_phase_reg marks the first inner cycle where candidate data returns.
    logic [FillW-1:0] k_rank;
    assign k_rank = fill_reg >> 1;
    assign ram_raddr = cmd.scan_outer ? ring(oldest_reg, oi_reg) : ring(oldest_reg, ii_reg);

    logic [FillW-1:0] less_now;
    logic [FillW-1:0] same_now;

    // inner: the first step latches the candidate; each later step compares entry ii-1
    logic [FillW:0] inner_cnt_reg;

    always_comb
    begin
        less_now = less_reg;
        same_now = same_reg;
        if (ram_rdata < cand_reg)
        begin
            less_now = less_reg + 1'b1;
        end
        else if (ram_rdata == cand_reg)
        begin
            same_now = same_reg + 1'b1;
        end
    end

    assign sts.item_ok    = ok_reg && !first_reg;
    assign sts.need_scan  = fill_reg >= FILL_MIN;
    assign sts.inner_last = !rd_phase_reg && (inner_cnt_reg == {1'b0, fill_reg});
    assign sts.outer_last = oi_reg == fill_reg;
    assign sts.found      = found_reg;

    // commit decisions
    logic        is_stall;
    logic [31:0] rec_val;
    logic        push;
    logic [48:0] rec_sum_wide;
    assign is_stall = {16'd0, gap_reg} > limit_reg;
    assign rec_val  = (gap_reg > base_reg) ? gap_reg - base_reg : 32'd0;
    assign push     = !is_stall && ((fill_reg < FILL_MIN) || (gap_reg >= (base_reg >> 2)));
    assign rec_sum_wide = {1'b0, rec_sum_reg} + {17'd0, rec_val};
    assign ram_we    = cmd.commit && sts.item_ok && push;
    assign ram_waddr = (fill_reg < FILL_MAX) ? ring(oldest_reg, fill_reg) : oldest_reg;

    logic [31:0] acc_next_val;
    logic [31:0] stall_next_val;
    assign acc_next_val   = (ok_reg && acc_total_reg != '1) ? acc_total_reg + 1'b1 : acc_total_reg;
    assign stall_next_val = (sts.item_ok && is_stall && stall_total_reg != '1)
                            ? stall_total_reg + 1'b1 : stall_total_reg;

    logic [48:0] gap_diff;
    assign gap_diff = {1'b0, in_arrival} - {1'b0, prior_arr_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ok_reg    <= in_ok;
            first_reg <= !have_prior_reg;
            arr_reg   <= in_arrival;
            seq_reg   <= in_sequence;
            if (gap_diff[48])
            begin
                gap_reg <= 32'd0;
            end
            else if (gap_diff[47:32] != 16'd0)
            begin
                gap_reg <= '1;
            end
            else
            begin
                gap_reg <= gap_diff[31:0];
            end
            base_reg <= {16'd0, seed_cycle_ms} * 32'd1000;
        end
        if (cmd.scan_start)
        begin
            oi_reg    <= '0;
            found_reg <= 1'b0;
        end
        if (cmd.scan_outer)
        begin
            rd_phase_reg  <= 1'b1;
            ii_reg        <= '0;
            inner_cnt_reg <= '0;
            less_reg      <= '0;
            same_reg      <= '0;
        end
        if (cmd.scan_inner)
        begin
            if (rd_phase_reg)
            begin
                rd_phase_reg <= 1'b0;
                cand_reg     <= ram_rdata;
                ii_reg       <= ii_reg + 1'b1;
                inner_cnt_reg <= inner_cnt_reg + 1'b1;
            end
            else
            begin
                less_reg <= less_now;
                same_reg <= same_now;
                if (ii_reg < FILL_MAX)
                begin
                    ii_reg <= ii_reg + 1'b1;
                end
                inner_cnt_reg <= inner_cnt_reg + 1'b1;
                if (sts.inner_last)
                begin
                    oi_reg <= oi_reg + 1'b1;
                    if (less_now <= k_rank && k_rank < less_now + same_now)
                    begin
                        found_reg <= 1'b1;
                        base_reg  <= cand_reg;
                    end
                end
            end
        end
        if (cmd.decide)
        begin
            limit_reg <= 48'(({16'd0, base_reg} * {32'd0, threshold_q8}) >> 8);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prior_reg  <= 1'b0;
            prior_seq_reg   <= '0;
            prior_arr_reg   <= '0;
            fill_reg        <= '0;
            oldest_reg      <= '0;
            acc_total_reg   <= '0;
            stall_total_reg <= '0;
            rec_sum_reg     <= '0;
            out_valid       <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                out_valid     <= 1'b1;
                acc_total_reg <= acc_next_val;
                if (ok_reg)
                begin
                    have_prior_reg <= 1'b1;
                    prior_seq_reg  <= seq_reg;
                    prior_arr_reg  <= arr_reg;
                end
                if (sts.item_ok)
                begin
                    stall_total_reg <= stall_next_val;
                    if (is_stall)
                    begin
                        rec_sum_reg <= rec_sum_wide[48] ? '1 : rec_sum_wide[47:0];
                    end
                    else if (push)
                    begin
                        if (fill_reg < FILL_MAX)
                        begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                        else
                        begin
                            oldest_reg <= (oldest_reg == IDX_LAST) ? '0 : oldest_reg + 1'b1;
                        end
                    end
                end
            end
            else if (out_valid && !out_stall)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            o_accepted   <= ok_reg;
            o_first      <= ok_reg && first_reg;
            o_stall_flag <= sts.item_ok && is_stall;
            o_recovery   <= (sts.item_ok && is_stall) ? rec_val : 32'd0;
            o_gap        <= sts.item_ok ? gap_reg : 32'd0;
            o_baseline   <= sts.item_ok ? base_reg : 32'd0;
            o_seq_break  <= sts.item_ok && (seq_reg != prior_seq_reg + 64'd1);
            o_flagged    <= sts.item_ok ? stall_next_val : stall_total_reg;
            o_received   <= acc_next_val;
            if (sts.item_ok && is_stall)
            begin
                o_rec_total <= rec_sum_wide[48] ? '1 : rec_sum_wide[47:0];
            end
            else
            begin
                o_rec_total <= rec_sum_reg;
            end
            o_stop <= (loss_target != 16'd0) &&
                      ((sts.item_ok ? stall_next_val : stall_total_reg) >= {16'd0, loss_target});
        end
    end
endmodule

// ===== rtl/arrival_gap_stall_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arrival_gap_stall_detector
// Interarrival gap stall detector with median-of-window baseline.
// Sequence: an ignored or first item goes capture, check, commit; a warm-up
//   item adds a decide step; with the median scan, candidates are tried in
//   window order (one RAM read per cycle) until the median is found.
// Throughput: one item at a time; the next transfer is taken in the cycle after
//   the result commits; commit waits on a stalled result.
// Reset: rst_n async, clears history, counters, window fill; registers reload.
// ----------------------------------------------------------------------------
module arrival_gap_stall_detector (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [47:0] arrival_us,
    input  logic [63:0] sequence_number,
    input  logic        payload_ok,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        accepted,
    output logic        first_item,
    output logic        stall_flag,
    output logic [31:0] recovery_time_us,
    output logic [31:0] gap_us,
    output logic [31:0] baseline_out_us,
    output logic        sequence_break,
    output logic [31:0] flagged_count,
    output logic [31:0] received_count,
    output logic [47:0] recovery_total_us,
    output logic        stop_request,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import agsd_pkg::*;

    logic [15:0] seed_reg;
    logic [15:0] thresh_reg;
    logic [15:0] loss_reg;
    agsd_cmd_t   cmd;
    agsd_sts_t   sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   <= 16'd1;
            thresh_reg <= 16'd768;
            loss_reg   <= 16'd10;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SEED:      seed_reg   <= cfg_data;
                REG_THRESHOLD: thresh_reg <= cfg_data;
                REG_LOSS:      loss_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    agsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    agsd_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .seed_cycle_ms (seed_reg),
        .threshold_q8  (thresh_reg),
        .loss_target   (loss_reg),
        .in_arrival    (arrival_us),
        .in_sequence   (sequence_number),
        .in_ok         (payload_ok),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .o_accepted    (accepted),
        .o_first       (first_item),
        .o_stall_flag  (stall_flag),
        .o_recovery    (recovery_time_us),
        .o_gap         (gap_us),
        .o_baseline    (baseline_out_us),
        .o_seq_break   (sequence_break),
        .o_flagged     (flagged_count),
        .o_received    (received_count),
        .o_rec_total   (recovery_total_us),
        .o_stop        (stop_request)
    );

    a_first_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && first_item |-> !stall_flag && gap_us == 32'd0)
        else $error("first item carries a gap");
    a_recovery_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !stall_flag |-> recovery_time_us == 32'd0)
        else $error("recovery without stall");
    a_ignored_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> !first_item && !stall_flag && !sequence_break)
        else $error("ignored item has flags");
endmodule
